/* rtl/fws_pkg.sv */
// ----------------------------------------------------------------------------
// Fixed-weight index sampler package
// Shared widths, reset values, register map, controller states and the
// command and status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package fws_pkg;

   // Default sizing of the top level.
   localparam int DEF_MAX_INDICES = 256;
   localparam int DEF_INDEX_WIDTH = 20;

   // Fixed widths of the interface fields.
   localparam int WORD_W      = 32;
   localparam int COUNT_W     = 9;
   localparam int BOUND_W     = 20;
   localparam int SLOT_W      = 8;
   localparam int OUT_INDEX_W = 20;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // Register reset values.
   localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd134;
   localparam logic [BOUND_W-1:0] BOUND_RESET = 20'd24646;

   // Register index, taken from bit 2 of the byte address.
   typedef enum logic {
      REG_INDEX_COUNT = 1'b0,
      REG_MAX_INDEX   = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic start;   // accept a word, open a run if none is active
      logic mul;     // form word * range
      logic add;     // form the candidate, clear the scan
      logic scan;    // issue one store read
      logic finish;  // write the store, load the result, step the position
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_end;  // the read just issued is the last entry
      logic out_free;  // the result register can take a new word
   } dp_status_type;

endpackage

/* rtl/fws_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fws_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/fws_csr.sv */
// ----------------------------------------------------------------------------
// Fixed-weight index sampler register block
// Holds the index count and the index bound behind an APB-style port.
// ----------------------------------------------------------------------------
module fws_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fws_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [fws_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [fws_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready,
   output logic [fws_pkg::COUNT_W-1:0]         index_count,
   output logic [fws_pkg::BOUND_W-1:0]         max_index_value
);

   logic [fws_pkg::COUNT_W-1:0] index_count_ff, index_count_in;
   logic [fws_pkg::BOUND_W-1:0] max_index_value_ff, max_index_value_in;
   logic                        wr_strobe;
   fws_pkg::reg_index_type      reg_sel;

   assign wr_strobe = psel & penable & pwrite;
   assign reg_sel   = fws_pkg::reg_index_type'(paddr[2]);
   assign pready    = 1'b1;

   always_comb begin
      index_count_in     = index_count_ff;
      max_index_value_in = max_index_value_ff;
      if (wr_strobe) begin
         case (reg_sel)
            fws_pkg::REG_INDEX_COUNT: begin
               index_count_in = pwdata[fws_pkg::COUNT_W-1:0];
            end
            fws_pkg::REG_MAX_INDEX: begin
               max_index_value_in = pwdata[fws_pkg::BOUND_W-1:0];
            end
            default: begin
               index_count_in = index_count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_count_ff     <= fws_pkg::COUNT_RESET;
         max_index_value_ff <= fws_pkg::BOUND_RESET;
      end else begin
         index_count_ff     <= index_count_in;
         max_index_value_ff <= max_index_value_in;
      end
   end

   always_comb begin
      case (reg_sel)
         fws_pkg::REG_INDEX_COUNT: prdata = fws_pkg::CSR_DATA_W'(index_count_ff);
         fws_pkg::REG_MAX_INDEX:   prdata = fws_pkg::CSR_DATA_W'(max_index_value_ff);
         default:                  prdata = '0;
      endcase
   end

   assign index_count     = index_count_ff;
   assign max_index_value = max_index_value_ff;

endmodule

/* rtl/fws_datapath.sv */
// ----------------------------------------------------------------------------
// Fixed-weight index sampler datapath
// Run and position registers, the candidate multiplier, the store of chosen
// indices with its duplicate scan, and the result register.
// ----------------------------------------------------------------------------
module fws_datapath #(
   parameter int MAX_INDICES = fws_pkg::DEF_MAX_INDICES,
   parameter int INDEX_WIDTH = fws_pkg::DEF_INDEX_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  fws_pkg::ctrl_cmd_type            cmd,
   output fws_pkg::dp_status_type           status,
   input  logic [fws_pkg::WORD_W-1:0]       random_word,
   input  logic [fws_pkg::COUNT_W-1:0]      index_count,
   input  logic [fws_pkg::BOUND_W-1:0]      max_index_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [fws_pkg::SLOT_W-1:0]       rsp_slot_position,
   output logic [fws_pkg::OUT_INDEX_W-1:0]  rsp_chosen_index,
   output logic                             rsp_was_duplicate,
   output logic                             rsp_run_last
);

   localparam int POS_W  = $clog2(MAX_INDICES);
   localparam int LEN_W  = $clog2(MAX_INDICES + 1);
   localparam int PROD_W = fws_pkg::WORD_W + fws_pkg::BOUND_W;
   localparam int SUM_W  = fws_pkg::BOUND_W + 1;

   // Run state.
   logic              run_active_ff, run_active_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [LEN_W-1:0]  run_len_ff, run_len_in;

   // Per-word work registers.
   logic [fws_pkg::WORD_W-1:0]  word_ff, word_in;
   logic [PROD_W-1:0]           prod_ff, prod_in;
   logic [INDEX_WIDTH-1:0]      cand_ff, cand_in;
   logic [POS_W-1:0]            scan_addr_ff, scan_addr_in;
   logic [POS_W-1:0]            cmp_idx_ff, cmp_idx_in;
   logic                        cmp_valid_ff, cmp_valid_in;
   logic                        dup_ff, dup_in;

   // Result register.
   logic                           out_valid_ff, out_valid_in;
   logic [fws_pkg::SLOT_W-1:0]     out_slot_ff, out_slot_in;
   logic [fws_pkg::OUT_INDEX_W-1:0] out_index_ff, out_index_in;
   logic                           out_dup_ff, out_dup_in;
   logic                           out_last_ff, out_last_in;

   logic [31:0]             run_len_sat;
   logic [fws_pkg::BOUND_W-1:0] range;
   logic [INDEX_WIDTH-1:0]  chosen;
   logic [INDEX_WIDTH-1:0]  rd_data;
   logic                    in_run;
   logic                    hit;

   fws_ram #(
      .WIDTH (INDEX_WIDTH),
      .DEPTH (MAX_INDICES)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.finish),
      .wr_addr (pos_ff),
      .wr_data (chosen),
      .rd_en   (cmd.scan),
      .rd_addr (scan_addr_ff),
      .rd_data (rd_data)
   );

   // Run length: zero counts as one, and it saturates at the store depth.
   always_comb begin
      run_len_sat = (index_count == '0) ? 32'd1 : 32'(index_count);
      if (run_len_sat > 32'(MAX_INDICES)) begin
         run_len_sat = 32'(MAX_INDICES);
      end
   end

   assign range = (32'(max_index_value) > 32'(pos_ff))
                ? fws_pkg::BOUND_W'(32'(max_index_value) - 32'(pos_ff)) : '0;

   assign in_run = (32'(cmp_idx_ff) > 32'(pos_ff)) && (32'(cmp_idx_ff) < 32'(run_len_ff));
   assign hit    = cmp_valid_ff && in_run && (rd_data == cand_ff);
   assign chosen = dup_ff ? INDEX_WIDTH'(pos_ff) : cand_ff;

   always_comb begin
      run_active_in = run_active_ff;
      pos_in        = pos_ff;
      run_len_in    = run_len_ff;
      word_in       = word_ff;
      prod_in       = prod_ff;
      cand_in       = cand_ff;
      scan_addr_in  = scan_addr_ff;
      cmp_idx_in    = scan_addr_ff;
      cmp_valid_in  = cmd.scan;
      dup_in        = dup_ff | hit;
      out_valid_in  = out_valid_ff & ~rsp_ready;
      out_slot_in   = out_slot_ff;
      out_index_in  = out_index_ff;
      out_dup_in    = out_dup_ff;
      out_last_in   = out_last_ff;

      if (cmd.start) begin
         word_in = random_word;
         if (!run_active_ff) begin
            run_active_in = 1'b1;
            run_len_in    = LEN_W'(run_len_sat);
            pos_in        = POS_W'(run_len_sat - 32'd1);
         end
      end
      if (cmd.mul) begin
         prod_in = PROD_W'(word_ff) * PROD_W'(range);
      end
      if (cmd.add) begin
         cand_in      = INDEX_WIDTH'(SUM_W'(pos_ff)
                      + SUM_W'(prod_ff[PROD_W-1:fws_pkg::WORD_W]));
         scan_addr_in = '0;
         dup_in       = 1'b0;
      end
      if (cmd.scan) begin
         scan_addr_in = scan_addr_ff + POS_W'(1);
      end
      if (cmd.finish) begin
         out_valid_in = 1'b1;
         out_slot_in  = fws_pkg::SLOT_W'(pos_ff);
         out_index_in = fws_pkg::OUT_INDEX_W'(chosen);
         out_dup_in   = dup_ff;
         out_last_in  = (pos_ff == '0);
         if (pos_ff == '0) begin
            run_active_in = 1'b0;
         end else begin
            pos_in = pos_ff - POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_active_ff <= 1'b0;
         pos_ff        <= '0;
         run_len_ff    <= '0;
         cmp_valid_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         run_active_ff <= run_active_in;
         pos_ff        <= pos_in;
         run_len_ff    <= run_len_in;
         cmp_valid_ff  <= cmp_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff      <= word_in;
      prod_ff      <= prod_in;
      cand_ff      <= cand_in;
      scan_addr_ff <= scan_addr_in;
      cmp_idx_ff   <= cmp_idx_in;
      dup_ff       <= dup_in;
      out_slot_ff  <= out_slot_in;
      out_index_ff <= out_index_in;
      out_dup_ff   <= out_dup_in;
      out_last_ff  <= out_last_in;
   end

   assign status.scan_end = (scan_addr_ff == POS_W'(MAX_INDICES - 1));
   assign status.out_free = ~out_valid_ff | rsp_ready;

   assign rsp_valid         = out_valid_ff;
   assign rsp_slot_position = out_slot_ff;
   assign rsp_chosen_index  = out_index_ff;
   assign rsp_was_duplicate = out_dup_ff;
   assign rsp_run_last      = out_last_ff;

endmodule

/* rtl/fws_controller.sv */
// ----------------------------------------------------------------------------
// Fixed-weight index sampler controller
// Sequences one word through multiply, add, store scan and write-back.
// ----------------------------------------------------------------------------
module fws_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  fws_pkg::dp_status_type  status,
   output fws_pkg::ctrl_cmd_type   cmd
);

   fws_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fws_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         fws_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = fws_pkg::ST_MUL;
            end
         end
         fws_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = fws_pkg::ST_ADD;
         end
         fws_pkg::ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = fws_pkg::ST_SCAN;
         end
         fws_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_end) begin
               state_in = fws_pkg::ST_DRAIN;
            end
         end
         fws_pkg::ST_DRAIN: begin
            // The last read returns now and is folded into the duplicate flag.
            state_in = fws_pkg::ST_FINISH;
         end
         fws_pkg::ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = fws_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fws_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/fixed_weight_index_sampler.sv */
// ----------------------------------------------------------------------------
// Fixed-weight index sampler
// Draws runs of distinct indices below a configured bound, one index for each
// random word, in a time that does not depend on the data.
// ----------------------------------------------------------------------------
// Each accepted random word yields exactly one result word: the chosen index,
// the position it fills, whether the candidate collided and whether it closes
// the run. The time from one acceptance to the next does not depend on the
// data. It is set by the duplicate scan, which reads every entry of the
// chosen-index store through its single read port, one entry a cycle,
// whatever the run length or position; a full result register at write-back
// can hold a word longer. Around the scan come the acceptance, the
// multiplier, the candidate add, the last read return and the
// write-back. The result sits in an output register, so a new word is taken
// while an earlier result still waits; should the result register still be
// full when the next word completes, the block holds there until it drains.
// The index count is latched at the start of each run; the bound is used on
// every word. Registers are meant to be written only while the block is idle.
// The store needs no clearing after reset: the scan only counts entries that
// were written earlier in the same run.
// ----------------------------------------------------------------------------
module fixed_weight_index_sampler #(
   parameter int MAX_INDICES = fws_pkg::DEF_MAX_INDICES,
   parameter int INDEX_WIDTH = fws_pkg::DEF_INDEX_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,

   // Random word input.
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [fws_pkg::WORD_W-1:0]       req_random_word,

   // Result output.
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [fws_pkg::SLOT_W-1:0]       rsp_slot_position,
   output logic [fws_pkg::OUT_INDEX_W-1:0]  rsp_chosen_index,
   output logic                             rsp_was_duplicate,
   output logic                             rsp_run_last,

   // Register port.
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [fws_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [fws_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [fws_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);

   // The controller and the datapath meet only through these two structs.
   fws_pkg::ctrl_cmd_type   cmd;
   fws_pkg::dp_status_type  status;

   logic [fws_pkg::COUNT_W-1:0] index_count;
   logic [fws_pkg::BOUND_W-1:0] max_index_value;

   // Index count at byte address 0, bound at byte address 4.
   fws_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .index_count     (index_count),
      .max_index_value (max_index_value)
   );

   // The controller takes a new word only when it has finished the last one.
   fws_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fws_datapath #(
      .MAX_INDICES (MAX_INDICES),
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .random_word       (req_random_word),
      .index_count       (index_count),
      .max_index_value   (max_index_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_slot_position (rsp_slot_position),
      .rsp_chosen_index  (rsp_chosen_index),
      .rsp_was_duplicate (rsp_was_duplicate),
      .rsp_run_last      (rsp_run_last)
   );

endmodule

/* rtl/fws_checker.sv */
// ----------------------------------------------------------------------------
// Fixed-weight index sampler port checker
// Watches the top-level ports and flags behaviour the block must never show.
// ----------------------------------------------------------------------------
module fws_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [fws_pkg::WORD_W-1:0]       req_random_word,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [fws_pkg::SLOT_W-1:0]       rsp_slot_position,
   input  logic [fws_pkg::OUT_INDEX_W-1:0]  rsp_chosen_index,
   input  logic                             rsp_was_duplicate,
   input  logic                             rsp_run_last,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [fws_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [fws_pkg::CSR_DATA_W-1:0]   pwdata,
   input  logic [fws_pkg::CSR_DATA_W-1:0]   prdata,
   input  logic                             pready
);

   // A stalled result word keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot_position)
         && $stable(rsp_chosen_index) && $stable(rsp_was_duplicate)
         && $stable(rsp_run_last))
      else $error("result word changed while stalled");

   // Only one word is in work at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word accepted while one is in work");

   // A result cannot appear in the cycle straight after a word is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   // The last word of a run always fills position zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_last |-> rsp_slot_position == '0)
      else $error("run closed at a non-zero position");

   // The register port never inserts wait states.
   assert property (@(posedge clock) disable iff (reset)
      psel |-> pready)
      else $error("register port stalled");

endmodule

bind fixed_weight_index_sampler fws_checker u_fws_checker (.*);
